>>> hdl/tsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and codes of the i2c master transaction sequencer.
// ----------------------------------------------------------------------------
package tsq_pkg;

  // opcodes of an input item
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;
  localparam logic [2:0] OP_TMO    = 3'd4;

  // controller status codes
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_TXD_ACK   = 8'h28;
  localparam logic [7:0] ST_TXD_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RXD_ACK   = 8'h50;
  localparam logic [7:0] ST_RXD_NACK  = 8'h58;
  localparam logic [7:0] ST_BUS_ERR   = 8'h00;
  localparam logic [7:0] ST_NO_INFO   = 8'hF8;

  // transaction modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // send and receive index limits
  localparam logic [4:0] IDX_MAX = 5'd31;
  localparam logic [3:0] RX_MAX  = 4'd15;

  // result queue depth
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic [2:0] op;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [3:0] len;
    logic [3:0] pos;
    logic [7:0] val;
    logic [7:0] st;
    logic [7:0] rxb;
  } item_t;

  typedef struct packed {
    logic       start;
    logic       stop;
    logic       clr;
    logic       ack;
    logic       sv;
    logic [7:0] sb;
    logic       rv;
    logic [3:0] rs;
    logic [7:0] rd;
    logic       done;
    logic       fail;
    logic       last;
  } res_t;

  // results handed from the decision stage to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

>>> hdl/tsq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/tsq_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_core
// Input register, transaction state and the per-item decision logic.
// ----------------------------------------------------------------------------
module tsq_core #(
  parameter int BUF_DEPTH   = 16,
  parameter int RETRY_LIMIT = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tsq_pkg::item_t in_item,
  input  wire logic           q_room,
  output tsq_pkg::push_t      push
);

  localparam int AW = $clog2(BUF_DEPTH);

  // input register
  logic           vld_r;
  tsq_pkg::item_t item_r;
  logic           byp_r;
  logic [7:0]     byp_data_r;

  // transaction state
  logic [1:0] mode_r, mode_nxt;
  logic [4:0] send_idx_r, send_idx_nxt;
  logic [4:0] byte_tgt_r, byte_tgt_nxt;
  logic [3:0] rx_idx_r, rx_idx_nxt;
  logic [3:0] retry_r, retry_nxt;
  logic [6:0] tgt_r, tgt_nxt;

  logic          fire;
  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    tx_rd;
  logic [7:0]    tx_byte;
  logic [4:0]    send_inc;
  logic [3:0]    rx_inc;
  logic [3:0]    retry_inc;
  logic          retry_hit;
  logic          bus_err;
  logic          do_retry;
  logic          do_tx;

  assign fire     = vld_r && q_room;
  assign in_ready = !vld_r || fire;
  assign in_acc   = in_valid && in_ready;

  // helpers for the decision
  assign tx_rd     = byp_r ? byp_data_r : ram_rdata;
  assign tx_byte   = (int'(send_idx_r) < BUF_DEPTH) ? tx_rd : 8'h00;
  assign send_inc  = (send_idx_r != tsq_pkg::IDX_MAX) ? send_idx_r + 5'd1 : send_idx_r;
  assign rx_inc    = (rx_idx_r != tsq_pkg::RX_MAX) ? rx_idx_r + 4'd1 : rx_idx_r;
  assign retry_inc = retry_r + 4'd1;
  assign retry_hit = int'(retry_inc) >= RETRY_LIMIT;
  assign bus_err   = (item_r.st == tsq_pkg::ST_ARB_LOST)  ||
                     (item_r.st == tsq_pkg::ST_BUS_ERR)   ||
                     (item_r.st == tsq_pkg::ST_TXD_NACK)  ||
                     (item_r.st == tsq_pkg::ST_NO_INFO)   ||
                     (item_r.st == tsq_pkg::ST_SLAR_NACK);

  // decision for the item in the input register
  always_comb begin
    push         = '0;
    mode_nxt     = mode_r;
    send_idx_nxt = send_idx_r;
    byte_tgt_nxt = byte_tgt_r;
    rx_idx_nxt   = rx_idx_r;
    retry_nxt    = retry_r;
    tgt_nxt      = tgt_r;
    wr_en        = 1'b0;
    wr_addr      = AW'(item_r.pos);
    wr_data      = item_r.val;
    do_retry     = 1'b0;
    do_tx        = 1'b0;
    if (fire) begin
      push.r0.last = 1'b1;
      unique case (item_r.op) inside
        tsq_pkg::OP_LOAD: begin
          wr_en = (item_r.pos != 4'd0) && (int'(item_r.pos) < BUF_DEPTH);
        end
        tsq_pkg::OP_WRITE, tsq_pkg::OP_READ: begin
          tgt_nxt      = item_r.dev;
          wr_en        = 1'b1;
          wr_addr      = '0;
          wr_data      = item_r.reg_addr;
          send_idx_nxt = 5'd0;
          if (item_r.op == tsq_pkg::OP_WRITE) begin
            byte_tgt_nxt = {1'b0, item_r.len} + 5'd1;
            mode_nxt     = tsq_pkg::MODE_WRITE;
          end else begin
            byte_tgt_nxt = {1'b0, item_r.len};
            rx_idx_nxt   = 4'd0;
            mode_nxt     = tsq_pkg::MODE_READ;
          end
          push.cnt      = 2'd1;
          push.r0.start = 1'b1;
        end
        tsq_pkg::OP_TMO: begin
          push.cnt     = 2'd1;
          push.r0.stop = 1'b1;
          push.r0.clr  = 1'b1;
          push.r0.done = 1'b1;
          push.r0.fail = 1'b1;
        end
        tsq_pkg::OP_STATUS: begin
          if (bus_err) begin
            // stop with clear, then a fresh start
            push.cnt      = 2'd2;
            push.r0.stop  = 1'b1;
            push.r0.clr   = 1'b1;
            push.r0.last  = 1'b0;
            push.r1.start = 1'b1;
            push.r1.last  = 1'b1;
          end else if (mode_r == tsq_pkg::MODE_WRITE || mode_r == tsq_pkg::MODE_READ) begin
            push.cnt    = 2'd1;
            push.r0.clr = 1'b1;
            if (item_r.st == tsq_pkg::ST_START) begin
              push.r0.sv = 1'b1;
              push.r0.sb = {tgt_r, 1'b0};
            end else if (item_r.st == tsq_pkg::ST_SLAW_ACK) begin
              do_tx = 1'b1;
            end else if (item_r.st == tsq_pkg::ST_SLAW_NACK) begin
              do_retry = 1'b1;
            end else if (item_r.st == tsq_pkg::ST_TXD_ACK) begin
              if (mode_r == tsq_pkg::MODE_WRITE) begin
                if (send_idx_r != byte_tgt_r) begin
                  do_tx = 1'b1;
                end else begin
                  push.r0.stop = 1'b1;
                  push.r0.done = 1'b1;
                end
              end else begin
                push.r0.start = 1'b1;
              end
            end else if (mode_r == tsq_pkg::MODE_READ && item_r.st == tsq_pkg::ST_RSTART) begin
              push.r0.sv = 1'b1;
              push.r0.sb = {tgt_r, 1'b1};
            end else if (mode_r == tsq_pkg::MODE_READ &&
                         item_r.st == tsq_pkg::ST_SLAR_ACK) begin
              push.r0.ack = byte_tgt_r > 5'd1;
            end else if (mode_r == tsq_pkg::MODE_READ &&
                         item_r.st == tsq_pkg::ST_RXD_NACK) begin
              push.r0.rv   = 1'b1;
              push.r0.rs   = rx_idx_r;
              push.r0.rd   = item_r.rxb;
              rx_idx_nxt   = rx_inc;
              push.r0.stop = 1'b1;
              push.r0.done = 1'b1;
            end else if (mode_r == tsq_pkg::MODE_READ &&
                         item_r.st == tsq_pkg::ST_RXD_ACK) begin
              push.r0.rv  = 1'b1;
              push.r0.rs  = rx_idx_r;
              push.r0.rd  = item_r.rxb;
              rx_idx_nxt  = rx_inc;
              // ack while more than one byte is still to come
              push.r0.ack = ({1'b0, rx_inc} + 5'd1) < byte_tgt_r;
            end else begin
              do_retry = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // next data byte from the tx buffer
      if (do_tx) begin
        push.r0.sv   = 1'b1;
        push.r0.sb   = tx_byte;
        send_idx_nxt = send_inc;
      end
      // nack or unknown code: retry until the global limit
      if (do_retry) begin
        push.r0.stop = 1'b1;
        if (retry_hit) begin
          retry_nxt    = 4'd0;
          push.r0.done = 1'b1;
          push.r0.fail = 1'b1;
        end else begin
          retry_nxt     = retry_inc;
          push.r0.start = 1'b1;
        end
      end
    end
  end

  // prefetch the tx byte for the send index the next item will see
  assign rd_addr = AW'(send_idx_nxt);
  assign rd_en   = in_acc && (int'(send_idx_nxt) < BUF_DEPTH);

  tsq_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // input register payload and write bypass
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r     <= in_item;
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      mode_r     <= tsq_pkg::MODE_IDLE;
      send_idx_r <= 5'd0;
      byte_tgt_r <= 5'd0;
      rx_idx_r   <= 4'd0;
      retry_r    <= 4'd0;
      tgt_r      <= 7'd0;
    end else begin
      if (in_ready) begin
        vld_r <= in_valid;
      end
      mode_r     <= mode_nxt;
      send_idx_r <= send_idx_nxt;
      byte_tgt_r <= byte_tgt_nxt;
      rx_idx_r   <= rx_idx_nxt;
      retry_r    <= retry_nxt;
      tgt_r      <= tgt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // the retry counter never rests at or above its limit
  a_retry_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(retry_r) < RETRY_LIMIT)
    else $error("retry count reached its limit without clearing");

  // the receive index only moves back at the start of a read
  a_rx_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && item_r.op == tsq_pkg::OP_READ) |=> rx_idx_r >= $past(rx_idx_r))
    else $error("receive index moved back outside a read start");

  // a pair of results carries the last mark on the second only
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.r0.last && push.r1.last)
    else $error("last mark misplaced in a result pair");
`endif

endmodule
`default_nettype wire

>>> hdl/tsq_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_outq
// Small result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module tsq_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tsq_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tsq_pkg::res_t       out_res
);

  localparam int PW = $clog2(tsq_pkg::Q_DEPTH);
  localparam int CW = PW + 1;

  tsq_pkg::res_t mem_r [tsq_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          pop;

  assign room      = int'(cnt_r) <= tsq_pkg::Q_DEPTH - 2;
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.r1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      cnt_r    <= cnt_r + CW'(push.cnt) - CW'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  // never more results held than entries
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= tsq_pkg::Q_DEPTH)
    else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

>>> hdl/i2c_master_transaction_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// Turns transaction requests and i2c controller status codes into control
// actions, transmit bytes and received bytes.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  in_*     | slave     | requests, tx loads, status events, timeouts
//  out_*    | master    | control action, send byte, rx byte, done/failed
//
//  one item is accepted per cycle while the result queue has room; its results
//  pass from the input register into the result queue and leave it at one
//  per cycle while out_tready is high; a bus error or arbitration loss gives
//  two results, so such items drain at half rate; the four-entry result queue
//  sets how far input runs ahead; the input register holds its item while the
//  queue has room for fewer than two results, and in_tready then stays low
//  reset clears state and queue; tx buffer contents stay undefined until loaded
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top #(
  parameter int BUF_DEPTH   = 16,
  parameter int RETRY_LIMIT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // device_address[6:0], register_address[14:7], length[18:15],
  // tx_position[22:19], tx_value[30:23], bus_status[38:31], received_byte[46:39]
  input  wire logic [47:0] in_tdata,
  // opcode[2:0]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // do_start[0], do_stop[1], do_clear[2], do_ack[3], send_valid[4],
  // send_byte[12:5], rx_valid[13], rx_slot[17:14], rx_data[25:18],
  // done_res[26], failed[27]
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  tsq_pkg::item_t in_item;
  tsq_pkg::push_t push;
  tsq_pkg::res_t  res;
  logic           q_room;

  // unpack the input item
  assign in_item.op       = in_tuser;
  assign in_item.dev      = in_tdata[6:0];
  assign in_item.reg_addr = in_tdata[14:7];
  assign in_item.len      = in_tdata[18:15];
  assign in_item.pos      = in_tdata[22:19];
  assign in_item.val      = in_tdata[30:23];
  assign in_item.st       = in_tdata[38:31];
  assign in_item.rxb      = in_tdata[46:39];

  tsq_core #(
    .BUF_DEPTH   (BUF_DEPTH),
    .RETRY_LIMIT (RETRY_LIMIT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_room   (q_room),
    .push     (push)
  );

  tsq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result item
  assign out_tdata = {4'b0000, res.fail, res.done, res.rd, res.rs, res.rv,
                      res.sb, res.sv, res.ack, res.clr, res.stop, res.start};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

>>> dv/i2c_master_transaction_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top_tb
// Self-checking bench for the i2c transaction sequencer. A queue of items
// (tx loads, write and read requests, status events, timeouts) is driven
// with random gaps. A local copy of the sequencer state predicts every
// control action. The result stream is checked field by field, under random
// back-pressure.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top_tb;

  localparam int MEM_DEPTH   = 16;
  localparam int RETRY_MAX   = 10;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  i2c_master_transaction_sequencer_top #(
    .BUF_DEPTH  (MEM_DEPTH),
    .RETRY_LIMIT(RETRY_MAX)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  tsq_pkg::item_t pending_items[$];
  tsq_pkg::res_t  expected_actions[$];
  tsq_pkg::item_t cur_item;
  int             items_accepted = 0;
  int             mismatches = 0;
  logic           no_idle;

  // stretch of items with neither side idling
  assign no_idle = (items_accepted >= 400) && (items_accepted < 650);

  // sequencer state as the block should hold it
  logic [1:0] seq_mode = tsq_pkg::MODE_IDLE;
  logic [7:0] tx_mem[MEM_DEPTH];
  logic [4:0] send_idx = '0;
  logic [4:0] byte_tgt = '0;
  logic [3:0] rx_idx = '0;
  logic [3:0] retries = '0;
  logic [6:0] tgt_addr = '0;

  function automatic logic [7:0] next_tx_byte();
    logic [7:0] b;
    b = (send_idx < MEM_DEPTH) ? tx_mem[send_idx[3:0]] : 8'h00;
    if (send_idx != tsq_pkg::IDX_MAX) send_idx = send_idx + 5'd1;
    return b;
  endfunction

  // nack or unknown code: restart, or give up once the global count runs out
  function automatic void count_retry(inout tsq_pkg::res_t r);
    retries = retries + 4'd1;
    r.stop = 1'b1;
    r.clr  = 1'b1;
    if (retries >= RETRY_MAX) begin
      retries = '0;
      r.done  = 1'b1;
      r.fail  = 1'b1;
    end else begin
      r.start = 1'b1;
    end
  endfunction

  function automatic void take_rx_byte(inout tsq_pkg::res_t r, input logic [7:0] data);
    r.rv = 1'b1;
    r.rs = rx_idx;
    r.rd = data;
    if (rx_idx != tsq_pkg::RX_MAX) rx_idx = rx_idx + 4'd1;
  endfunction

  function automatic void predict_actions(tsq_pkg::item_t it);
    tsq_pkg::res_t r;
    r = '0;
    r.last = 1'b1;
    case (it.op) inside
      tsq_pkg::OP_LOAD: begin
        if (it.pos != 4'd0 && it.pos < MEM_DEPTH) tx_mem[it.pos] = it.val;
      end
      tsq_pkg::OP_WRITE, tsq_pkg::OP_READ: begin
        tgt_addr  = it.dev;
        tx_mem[0] = it.reg_addr;
        send_idx  = '0;
        if (it.op == tsq_pkg::OP_WRITE) begin
          byte_tgt = {1'b0, it.len} + 5'd1;
          seq_mode = tsq_pkg::MODE_WRITE;
        end else begin
          byte_tgt = {1'b0, it.len};
          rx_idx   = '0;
          seq_mode = tsq_pkg::MODE_READ;
        end
        r.start = 1'b1;
        expected_actions.push_back(r);
      end
      tsq_pkg::OP_TMO: begin
        r.stop = 1'b1;
        r.clr  = 1'b1;
        r.done = 1'b1;
        r.fail = 1'b1;
        expected_actions.push_back(r);
      end
      tsq_pkg::OP_STATUS: begin
        if (it.st inside {tsq_pkg::ST_ARB_LOST, tsq_pkg::ST_BUS_ERR, tsq_pkg::ST_TXD_NACK,
                          tsq_pkg::ST_NO_INFO, tsq_pkg::ST_SLAR_NACK}) begin
          // bus error or lost arbitration: stop, then start again
          r.stop = 1'b1;
          r.clr  = 1'b1;
          r.last = 1'b0;
          expected_actions.push_back(r);
          r = '0;
          r.start = 1'b1;
          r.last  = 1'b1;
          expected_actions.push_back(r);
        end else if (seq_mode == tsq_pkg::MODE_WRITE || seq_mode == tsq_pkg::MODE_READ) begin
          if (it.st == tsq_pkg::ST_START) begin
            r.sv  = 1'b1;
            r.sb  = {tgt_addr, 1'b0};
            r.clr = 1'b1;
          end else if (it.st == tsq_pkg::ST_SLAW_ACK) begin
            r.sv  = 1'b1;
            r.sb  = next_tx_byte();
            r.clr = 1'b1;
          end else if (it.st == tsq_pkg::ST_SLAW_NACK) begin
            count_retry(r);
          end else if (it.st == tsq_pkg::ST_TXD_ACK) begin
            r.clr = 1'b1;
            if (seq_mode == tsq_pkg::MODE_READ) begin
              r.start = 1'b1;
            end else if (send_idx != byte_tgt) begin
              r.sv = 1'b1;
              r.sb = next_tx_byte();
            end else begin
              r.stop = 1'b1;
              r.done = 1'b1;
            end
          end else if (seq_mode == tsq_pkg::MODE_READ && it.st == tsq_pkg::ST_RSTART) begin
            r.sv  = 1'b1;
            r.sb  = {tgt_addr, 1'b1};
            r.clr = 1'b1;
          end else if (seq_mode == tsq_pkg::MODE_READ && it.st == tsq_pkg::ST_SLAR_ACK) begin
            r.clr = 1'b1;
            r.ack = byte_tgt > 5'd1;
          end else if (seq_mode == tsq_pkg::MODE_READ && it.st == tsq_pkg::ST_RXD_NACK) begin
            take_rx_byte(r, it.rxb);
            r.stop = 1'b1;
            r.clr  = 1'b1;
            r.done = 1'b1;
          end else if (seq_mode == tsq_pkg::MODE_READ && it.st == tsq_pkg::ST_RXD_ACK) begin
            take_rx_byte(r, it.rxb);
            r.clr = 1'b1;
            r.ack = (int'(rx_idx) + 1) < int'(byte_tgt);
          end else begin
            count_retry(r);
          end
          expected_actions.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_actions(cur_item);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 27)) begin
          cur_item = pending_items.pop_front();
          in_tdata <= {1'b0, cur_item.rxb, cur_item.st, cur_item.val, cur_item.pos,
                       cur_item.len, cur_item.reg_addr, cur_item.dev};
          in_tuser <= cur_item.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    tsq_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_actions.size() == 0) begin
        $error("result item 0x%0h with nothing expected", out_tdata);
        mismatches++;
      end else begin
        want = expected_actions.pop_front();
        check_field("do_start", want.start, out_tdata[0]);
        check_field("do_stop", want.stop, out_tdata[1]);
        check_field("do_clear", want.clr, out_tdata[2]);
        check_field("do_ack", want.ack, out_tdata[3]);
        check_field("send_valid", want.sv, out_tdata[4]);
        check_field("send_byte", want.sb, out_tdata[12:5]);
        check_field("rx_valid", want.rv, out_tdata[13]);
        check_field("rx_slot", want.rs, out_tdata[17:14]);
        check_field("rx_data", want.rd, out_tdata[25:18]);
        check_field("done_res", want.done, out_tdata[26]);
        check_field("failed", want.fail, out_tdata[27]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // stimulus builders
  function automatic tsq_pkg::item_t rand_item(logic [2:0] op, logic [7:0] st);
    tsq_pkg::item_t it;
    it.op       = op;
    it.dev      = 7'($urandom_range(127));
    it.reg_addr = 8'($urandom_range(255));
    it.len      = 4'($urandom_range(15, 1));
    it.pos      = 4'($urandom_range(15, 1));
    it.val      = 8'($urandom_range(255));
    it.st       = st;
    it.rxb      = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic void add_status(logic [7:0] st);
    pending_items.push_back(rand_item(tsq_pkg::OP_STATUS, st));
  endfunction

  function automatic void add_load(logic [3:0] pos, logic [7:0] val);
    tsq_pkg::item_t it;
    it = rand_item(tsq_pkg::OP_LOAD, 8'h00);
    it.pos = pos;
    it.val = val;
    pending_items.push_back(it);
  endfunction

  function automatic void add_start(logic [2:0] op, logic [6:0] dev, logic [7:0] ra,
                                    logic [3:0] n);
    tsq_pkg::item_t it;
    it = rand_item(op, 8'h00);
    it.dev = dev;
    it.reg_addr = ra;
    it.len = n;
    pending_items.push_back(it);
  endfunction

  function automatic void add_noise();
    logic [7:0] bus_errs[4];
    bus_errs = '{tsq_pkg::ST_BUS_ERR, tsq_pkg::ST_TXD_NACK, tsq_pkg::ST_SLAR_NACK,
                 tsq_pkg::ST_NO_INFO};
    case ($urandom_range(9)) inside
      0, 1: add_status(tsq_pkg::ST_SLAW_NACK);
      2: add_status(bus_errs[$urandom_range(3)]);
      3: add_status(tsq_pkg::ST_ARB_LOST);
      4: add_status(8'($urandom_range(255)));
      5: pending_items.push_back(rand_item(tsq_pkg::OP_TMO, 8'($urandom_range(255))));
      6: pending_items.push_back(rand_item(3'($urandom_range(7, 5)), 8'h00));
      // runs of acks push the send index past the buffer
      7: repeat ($urandom_range(20, 2)) add_status(tsq_pkg::ST_SLAW_ACK);
      // and the rx index into saturation
      8: repeat ($urandom_range(20, 2)) add_status(tsq_pkg::ST_RXD_ACK);
      default: add_load(4'($urandom_range(15)), 8'($urandom_range(255)));
    endcase
  endfunction

  // one well-formed transaction, now and then with noise or broken off
  function automatic void add_transaction();
    logic       is_read;
    int         n;
    logic [7:0] steps[$];
    is_read = 1'($urandom_range(1));
    n = $urandom_range(15, 1);
    add_start(is_read ? tsq_pkg::OP_READ : tsq_pkg::OP_WRITE, 7'($urandom_range(127)),
              8'($urandom_range(255)), 4'(n));
    steps = '{tsq_pkg::ST_START, tsq_pkg::ST_SLAW_ACK};
    if (!is_read) begin
      repeat (n + 1) steps.push_back(tsq_pkg::ST_TXD_ACK);
    end else begin
      steps.push_back(tsq_pkg::ST_TXD_ACK);
      steps.push_back(tsq_pkg::ST_RSTART);
      steps.push_back(tsq_pkg::ST_SLAR_ACK);
      repeat (n - 1) steps.push_back(tsq_pkg::ST_RXD_ACK);
      steps.push_back(tsq_pkg::ST_RXD_NACK);
    end
    foreach (steps[i]) begin
      if ($urandom_range(99) < 3) return;
      if ($urandom_range(99) < 6) add_noise();
      add_status(steps[i]);
    end
  endfunction

  // stimulus and end of run
  initial begin
    int total_items;

    // every tx slot gets a value before anything can send it
    for (int s = 1; s < MEM_DEPTH; s++) add_load(4'(s), 8'($urandom_range(255)));

    // status events while idle, errors, timeout, unused opcodes, slot zero
    add_status(tsq_pkg::ST_START);
    add_status(tsq_pkg::ST_SLAW_NACK);
    add_status(8'hFF);
    add_status(tsq_pkg::ST_BUS_ERR);
    add_status(tsq_pkg::ST_ARB_LOST);
    pending_items.push_back(rand_item(tsq_pkg::OP_TMO, 8'h00));
    pending_items.push_back(rand_item(3'd5, 8'h00));
    pending_items.push_back(rand_item(3'd7, 8'h00));
    add_load(4'd0, 8'hFF);

    // shortest write at the top addresses, one extra ack after the stop
    add_start(tsq_pkg::OP_WRITE, 7'h7F, 8'hFF, 4'd1);
    add_status(tsq_pkg::ST_START);
    add_status(tsq_pkg::ST_SLAW_ACK);
    add_status(tsq_pkg::ST_TXD_ACK);
    add_status(tsq_pkg::ST_TXD_ACK);
    add_status(tsq_pkg::ST_TXD_ACK);

    // shortest read at the bottom addresses
    add_start(tsq_pkg::OP_READ, 7'h00, 8'h00, 4'd1);
    add_status(tsq_pkg::ST_START);
    add_status(tsq_pkg::ST_SLAW_ACK);
    add_status(tsq_pkg::ST_TXD_ACK);
    add_status(tsq_pkg::ST_RSTART);
    add_status(tsq_pkg::ST_SLAR_ACK);
    add_status(tsq_pkg::ST_RXD_NACK);

    // random part
    while (pending_items.size() < 1040) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1)) add_load(4'($urandom_range(15, 1)),
                                               8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0) add_noise();
      add_transaction();
    end
    total_items = pending_items.size();

    while (items_accepted != total_items) @(posedge clk);
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
hdl/tsq_pkg.sv
hdl/tsq_ram.sv
hdl/tsq_core.sv
hdl/tsq_outq.sv
hdl/i2c_master_transaction_sequencer_top.sv
dv/i2c_master_transaction_sequencer_top_tb.sv
